### rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and constants for the byte ring deque.
// ----------------------------------------------------------------------------
package brd_pkg;

  localparam int BYTE_W = 8;

  // request command codes
  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,  // append at newest end
    CMD_GET  = 2'd1,  // remove oldest
    CMD_PEEK = 2'd2,  // read oldest, keep it
    CMD_POP  = 2'd3   // remove newest
  } cmd_t;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

### rtl/brd_intf.sv
// ----------------------------------------------------------------------------
// brd_intf
// Valid/ready channels for deque requests and results.
// ----------------------------------------------------------------------------
interface brd_cmd_if import brd_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  byte_t data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface brd_res_if import brd_pkg::*; #(
  parameter int CNT_W = 7
) ();
  logic             valid;
  logic             ready;
  byte_t            data_out;
  logic             error;
  logic [CNT_W-1:0] fill_count;

  modport source (output valid, output data_out, output error, output fill_count,
                  input ready);
  modport sink   (input valid, input data_out, input error, input fill_count,
                  output ready);
endinterface

### rtl/brd_store.sv
// ----------------------------------------------------------------------------
// brd_store
// Byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brd_store import brd_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  byte_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output byte_t             rd_data
);

  byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/byte_ring_deque_top.sv
// ----------------------------------------------------------------------------
// byte_ring_deque_top
// Circular byte store of DEPTH entries used as a double-ended queue.
// ----------------------------------------------------------------------------
//
//   channel | modport           | payload
//   --------+-------------------+------------------------------------------
//   req     | brd_cmd_if.sink   | command, data_in
//   rsp     | brd_res_if.source | data_out, error, fill_count
//
// one request is taken per cycle while req.ready is high; its result appears in the
// next cycle, with the memory read register serving as the result register
// the memory's single registered read port sets when the result appears
// reset (synchronous, rst high) empties the queue; memory contents are left as is
// while a result waits on rsp, req.ready stays low; it rises again in the cycle the
// result is taken, so with rsp.ready held high a steady stream runs at one request per cycle
module byte_ring_deque_top import brd_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  brd_cmd_if.sink          req,
  brd_res_if.source        rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // queue state
  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;

  // result register
  logic             out_valid;
  logic             out_error;
  logic             out_hit;      // result carries a byte from the store
  logic [CNT_W-1:0] out_count;
  byte_t            rd_data;

  // memory port controls
  logic             wr_en;
  logic             rd_en;
  logic             hit;
  logic             err;
  logic [IDX_W-1:0] rd_addr;

  logic             accept;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] write_up;
  logic [IDX_W-1:0] write_down;
  logic [IDX_W-1:0] read_up;

  // ready whenever the result register is free or being drained
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full  = (stored_count == CNT_W'(DEPTH));
  assign empty = (stored_count == '0);

  // index stepping modulo DEPTH, which need not be a power of two
  assign write_up   = (write_index == IDX_W'(DEPTH - 1)) ? '0 : write_index + 1'b1;
  assign write_down = (write_index == '0) ? IDX_W'(DEPTH - 1) : write_index - 1'b1;
  assign read_up    = (read_index == IDX_W'(DEPTH - 1)) ? '0 : read_index + 1'b1;

  always_comb begin
    write_index_next  = write_index;
    read_index_next   = read_index;
    stored_count_next = stored_count;
    wr_en             = 1'b0;
    hit               = 1'b0;
    err               = 1'b0;
    rd_addr           = read_index;
    unique case (req.command)
      CMD_PUT: begin
        if (full) begin
          err = 1'b1;
        end else begin
          wr_en             = accept;
          write_index_next  = write_up;
          stored_count_next = stored_count + 1'b1;
        end
      end
      CMD_GET: begin
        if (empty) begin
          err = 1'b1;
        end else begin
          hit               = 1'b1;
          read_index_next   = read_up;
          stored_count_next = stored_count - 1'b1;
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          err = 1'b1;
        end else begin
          hit = 1'b1;
        end
      end
      CMD_POP: begin
        // newest byte sits one slot behind the write index
        rd_addr = write_down;
        if (empty) begin
          err = 1'b1;
        end else begin
          hit               = 1'b1;
          write_index_next  = write_down;
          stored_count_next = stored_count - 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  // read on every accepted request so rd_data holds during a stall
  assign rd_en = accept;

  brd_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_index),
    .wr_data (req.data_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index  <= '0;
      read_index   <= '0;
      stored_count <= '0;
    end else if (accept) begin
      write_index  <= write_index_next;
      read_index   <= read_index_next;
      stored_count <= stored_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      out_error <= err;
      out_hit   <= hit;
      out_count <= stored_count_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.data_out   = out_hit ? rd_data : '0;
  assign rsp.error      = out_error;
  assign rsp.fill_count = out_count;

  // an error result is only possible with the queue empty or full
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.error) |-> (rsp.fill_count == '0 || rsp.fill_count == CNT_W'(DEPTH)))
    else $error("error result with a partly filled queue");

  // failed requests never return a byte
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.error) |-> (rsp.data_out == '0))
    else $error("error result carries data");

  // an empty or full queue has both indices on the same slot
  assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (write_index == read_index))
    else $error("indices disagree with count");

  // count never exceeds the depth
  assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(DEPTH))
    else $error("count beyond depth");

  // a rejected request leaves the queue state untouched
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(stored_count) && $stable(write_index) && $stable(read_index)))
    else $error("state moved without a request");

endmodule

### tb/deque_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_scoreboard_pkg
// Tracks the deque contents for each accepted request and compares every
// result from the block against the byte, error flag and count it predicts.
// ----------------------------------------------------------------------------
package deque_scoreboard_pkg;
  import brd_pkg::*;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = 7;

  typedef struct {
    cmd_t             command;
    byte_t            data_out;
    logic             error;
    logic [CNT_W-1:0] fill_count;
  } deque_result_t;

  class deque_scoreboard;
    byte_t            slots [SLOTS];
    logic [IDX_W-1:0] newest_idx;   // slot the next put fills
    logic [IDX_W-1:0] oldest_idx;   // slot of the oldest byte
    logic [CNT_W-1:0] held;
    deque_result_t    awaited_q[$];
    int               mismatches;

    function new();
      newest_idx = '0;
      oldest_idx = '0;
      held       = '0;
      mismatches = 0;
    endfunction

    function int pending_count();
      return awaited_q.size();
    endfunction

    // indices are IDX_W bits wide, so they wrap modulo SLOTS on their own
    function void note_request(cmd_t command, byte_t data_in);
      deque_result_t want;
      want.command  = command;
      want.data_out = '0;
      want.error    = 1'b0;
      if (command == CMD_PUT) begin
        if (held == SLOTS) begin
          want.error = 1'b1;
        end else begin
          slots[newest_idx] = data_in;
          newest_idx++;
          held++;
        end
      end else if (held == 0) begin
        want.error = 1'b1;
      end else begin
        case (command)
          CMD_GET: begin
            want.data_out = slots[oldest_idx];
            oldest_idx++;
            held--;
          end
          CMD_PEEK: begin
            want.data_out = slots[oldest_idx];
          end
          default: begin
            newest_idx--;
            want.data_out = slots[newest_idx];
            held--;
          end
        endcase
      end
      want.fill_count = held;
      awaited_q.push_back(want);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(byte_t data_out, logic error, logic [CNT_W-1:0] fill_count);
      deque_result_t want;
      if (awaited_q.size() == 0) begin
        report($sformatf("result %02h/%0b/%0d with no request waiting",
                         data_out, error, fill_count));
      end else begin
        want = awaited_q.pop_front();
        if (data_out !== want.data_out)
          report($sformatf("%s data_out %02h, want %02h", want.command.name(),
                           data_out, want.data_out));
        if (error !== want.error)
          report($sformatf("%s error %b, want %b", want.command.name(),
                           error, want.error));
        if (fill_count !== want.fill_count)
          report($sformatf("%s fill_count %0d, want %0d", want.command.name(),
                           fill_count, want.fill_count));
      end
    endtask
  endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives put, get, peek and pop requests into the byte ring deque and checks
// each result against a scoreboard that mirrors the queue contents.
// ----------------------------------------------------------------------------
module tb_top;
  import brd_pkg::*;
  import deque_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int PHASES       = 3;

  logic clk;
  logic rst;

  brd_cmd_if                  req_ch ();
  brd_res_if #(.CNT_W(CNT_W)) rsp_ch ();

  byte_ring_deque_top #(.DEPTH(SLOTS)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  deque_scoreboard sb = new();

  // idle rates in percent, changed per phase
  int send_idle_pct;
  int recv_idle_pct;

  // clock and the single reset at the start
  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.command = CMD_PUT;
    req_ch.data_in = '0;
    rsp_ch.ready   = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
  end

  // receiver side: ready toggles at the falling edge at the current stall rate
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor at the rising edge: results are checked before the request
  // taken at the same edge is noted, though queue order makes either safe
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.data_out, rsp_ch.error, rsp_ch.fill_count);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.command, req_ch.data_in);
    end
  end

  // called just after a falling edge; returns just after a falling edge
  // once the request has been taken
  task send_request(cmd_t command, byte_t data_in);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= command;
    req_ch.data_in <= data_in;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // hold requests off until every outstanding result has come back
  task hold_until_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  function cmd_t pick_read_command();
    return cmd_t'($urandom_range(int'(CMD_GET), int'(CMD_POP)));
  endfunction

  // burst styles: fill leans on put, drain leans on reads, the rest mix
  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_NOISE} burst_kind_t;

  task run_burst(burst_kind_t kind, int count);
    cmd_t command;
    int   roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      case (kind)
        BURST_FILL:  command = (roll < 90) ? CMD_PUT : pick_read_command();
        BURST_DRAIN: command = (roll < 90) ? pick_read_command() : CMD_PUT;
        BURST_MIXED: command = (roll < 50) ? CMD_PUT : pick_read_command();
        default:     command = cmd_t'($urandom_range(3));
      endcase
      send_request(command, byte_t'($urandom_range(255)));
    end
  endtask

  initial begin
    int          sent;
    int          budget;
    int          burst_len;
    burst_kind_t kind;

    send_idle_pct = 13;
    recv_idle_pct = 70;
    @(negedge clk);
    while (rst) @(negedge clk);

    // directed: empty-store errors on every read, both byte extremes,
    // newest-end pop against oldest-end get and peek
    send_request(CMD_GET,  8'h00);
    send_request(CMD_PEEK, 8'h11);
    send_request(CMD_POP,  8'h22);
    send_request(CMD_PUT,  8'h00);
    send_request(CMD_PUT,  8'hFF);
    send_request(CMD_PEEK, 8'h00);
    send_request(CMD_GET,  8'h00);
    send_request(CMD_POP,  8'h00);
    send_request(CMD_POP,  8'hFF);
    send_request(CMD_PUT,  8'hA5);
    send_request(CMD_PUT,  8'h5A);
    send_request(CMD_PUT,  8'h3C);
    send_request(CMD_GET,  8'h00);
    send_request(CMD_POP,  8'h00);
    send_request(CMD_PEEK, 8'h00);
    send_request(CMD_GET,  8'h00);
    send_request(CMD_GET,  8'h00);
    send_request(CMD_PUT,  8'h80);
    send_request(CMD_PUT,  8'h01);
    send_request(CMD_POP,  8'h00);
    send_request(CMD_GET,  8'h00);

    // random phases; each starts with no result outstanding and opens with a long fill burst
    // so the full case and put-on-full errors occur in every phase
    sent = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      hold_until_drained();
      budget = RANDOM_ITEMS * (phase + 1) / PHASES;
      // puts only, more than the depth, so the store fills and rejects puts
      for (int k = 0; k < 72; k++) begin
        send_request(CMD_PUT, byte_t'($urandom_range(255)));
      end
      sent += 72;
      while (sent < budget) begin
        kind      = burst_kind_t'($urandom_range(3));
        burst_len = $urandom_range(10, 80);
        if (burst_len > budget - sent) burst_len = budget - sent;
        run_burst(kind, burst_len);
        sent += burst_len;
      end
    end

    // wind down: let the last result drain before the final check
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (sb.pending_count() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_count()));
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
